// ----- rtl/dssfe_pkg.sv -----
// Package for the decimal seven-segment frame encoder.
// Holds request/job types, frame constants, front FSM states and the segment table.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package dssfe_pkg;

  localparam int unsigned NumDigits = 8;
  localparam int unsigned DigitIdxW = $clog2(NumDigits);
  localparam int unsigned DigitCntW = $clog2(NumDigits + 1);
  localparam int unsigned SlotW     = $clog2(NumDigits + 2);

  localparam logic [7:0] DataCommand = 8'h40;
  localparam logic [7:0] AddrBase    = 8'hC0;
  localparam logic [7:0] PointBit    = 8'h80;

  // divide by ten: (v * Recip10) >> Recip10Shift
  localparam logic [31:0] Recip10      = 32'hCCCC_CCCD;
  localparam int unsigned Recip10Shift = 35;

  localparam logic [SlotW-1:0] SlotCommand = SlotW'(0);
  localparam logic [SlotW-1:0] SlotAddress = SlotW'(1);

  typedef struct packed {
    logic [7:0]  start_position;
    logic [7:0]  count_of_digits;
    logic [31:0] value_to_show;
    logic        point_on;
  } dssfe_req_t;

  typedef struct packed {
    logic [7:0]                 start_position;
    logic [DigitCntW-1:0]       n_digits;
    logic [NumDigits-1:0][3:0]  digits;
    logic                       point_on;
  } dssfe_job_t;

  typedef struct packed {
    logic valid;
    logic full;
  } dssfe_q_stat_t;

  typedef enum logic [1:0] {
    FR_IDLE,
    FR_RUN,
    FR_PUSH
  } dssfe_front_state_e;

  function automatic logic [7:0] seg7(input logic [3:0] digit);
    logic [7:0] pattern;
    unique case (digit)
      4'd0:    pattern = 8'h3f;
      4'd1:    pattern = 8'h06;
      4'd2:    pattern = 8'h5b;
      4'd3:    pattern = 8'h4f;
      4'd4:    pattern = 8'h66;
      4'd5:    pattern = 8'h6d;
      4'd6:    pattern = 8'h7d;
      4'd7:    pattern = 8'h07;
      4'd8:    pattern = 8'h7f;
      4'd9:    pattern = 8'h6f;
      default: pattern = 8'h00;
    endcase
    return pattern;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/dssfe_if.sv -----
// Channel interfaces for the frame encoder: request in, bus byte out.
// Depends on nothing; payload fields carry the names of the frame fields.
`timescale 1ns / 1ps
`default_nettype none

interface dssfe_req_if;
  logic        valid;
  logic        ready;
  logic [7:0]  start_position;
  logic [7:0]  count_of_digits;
  logic [31:0] value_to_show;
  logic        point_on;

  modport source (output valid, start_position, count_of_digits, value_to_show, point_on,
                  input ready);
  modport sink (input valid, start_position, count_of_digits, value_to_show, point_on,
                output ready);
endinterface

interface dssfe_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] bus_byte;
  logic       opens_transfer;
  logic       closes_transfer;
  logic       last_of_run;

  modport source (output valid, bus_byte, opens_transfer, closes_transfer, last_of_run,
                  input ready);
  modport sink (input valid, bus_byte, opens_transfer, closes_transfer, last_of_run,
                output ready);
endinterface

`default_nettype wire

// ----- rtl/dssfe_front.sv -----
// Front end: holds one request and splits the number into decimal digits,
// one digit per cycle by reciprocal multiply, then pushes a job. Uses dssfe_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dssfe_front
  import dssfe_pkg::*;
(
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire dssfe_req_t    req_i,
  input  wire dssfe_q_stat_t q_stat_i,
  output logic               push_o,
  output dssfe_job_t         job_o
);

  dssfe_front_state_e state_q, state_d;

  logic                      hold_v_q, hold_v_d;
  dssfe_req_t                hold_q;
  logic [31:0]               v_q, v_d;
  logic [DigitIdxW-1:0]      cnt_q, cnt_d;
  logic [NumDigits-1:0][3:0] digs_q, digs_d;
  logic [7:0]                start_q, start_d;
  logic [DigitCntW-1:0]      n_q, n_d;
  logic                      point_q, point_d;

  logic                      take;
  logic                      in_fire;
  logic [63:0]               prod;
  logic [31:0]               quot;
  logic [31:0]               rem;
  logic [DigitCntW-1:0]      n_sat;

  assign prod = 64'(v_q) * 64'(Recip10);
  assign quot = 32'(prod[63:Recip10Shift]);
  assign rem  = v_q - (quot << 3) - (quot << 1);

  assign n_sat = (hold_q.count_of_digits > 8'(NumDigits)) ? DigitCntW'(NumDigits)
                                                          : hold_q.count_of_digits[DigitCntW-1:0];

  assign in_ready_o = !hold_v_q || take;
  assign in_fire    = in_valid_i && in_ready_o;

  assign job_o.start_position = start_q;
  assign job_o.n_digits       = n_q;
  assign job_o.digits         = digs_q;
  assign job_o.point_on       = point_q;

  always_comb begin
    state_d = state_q;
    v_d     = v_q;
    cnt_d   = cnt_q;
    digs_d  = digs_q;
    start_d = start_q;
    n_d     = n_q;
    point_d = point_q;
    push_o  = 1'b0;
    take    = 1'b0;

    unique case (state_q)
      FR_IDLE: begin
        take = hold_v_q;
      end
      FR_RUN: begin
        digs_d[cnt_q] = rem[3:0];
        v_d           = quot;
        cnt_d         = cnt_q + DigitIdxW'(1);
        if (cnt_q == DigitIdxW'(NumDigits - 1)) begin
          state_d = FR_PUSH;
        end
      end
      FR_PUSH: begin
        if (!q_stat_i.full) begin
          push_o  = 1'b1;
          take    = hold_v_q;
          state_d = FR_IDLE;
        end
      end
      default: state_d = FR_IDLE;
    endcase

    if (take) begin
      state_d = FR_RUN;
      v_d     = hold_q.value_to_show;
      cnt_d   = '0;
      start_d = hold_q.start_position;
      n_d     = n_sat;
      point_d = hold_q.point_on;
    end

    hold_v_d = in_fire ? 1'b1 : (take ? 1'b0 : hold_v_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= FR_IDLE;
      hold_v_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      hold_v_q <= hold_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      hold_q <= req_i;
    end
    v_q     <= v_d;
    cnt_q   <= cnt_d;
    digs_q  <= digs_d;
    start_q <= start_d;
    n_q     <= n_d;
    point_q <= point_d;
  end

endmodule

`default_nettype wire

// ----- rtl/dssfe_queue.sv -----
// Two-entry job queue between front and back ends.
// Uses dssfe_pkg for the job and status types.
`timescale 1ns / 1ps
`default_nettype none

module dssfe_queue
  import dssfe_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push_i,
  input  wire dssfe_job_t job_i,
  input  wire logic       pop_i,
  output dssfe_job_t      job_o,
  output dssfe_q_stat_t   stat_o
);

  dssfe_job_t mem_q [2];
  logic       wr_q, wr_d;
  logic       rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;

  assign stat_o.valid = (cnt_q != 2'd0);
  assign stat_o.full  = (cnt_q == 2'd2);
  assign job_o        = mem_q[rd_q];

  always_comb begin
    wr_d  = push_i ? !wr_q : wr_q;
    rd_d  = pop_i ? !rd_q : rd_q;
    cnt_d = cnt_q + 2'(push_i) - 2'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= job_i;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/dssfe_back.sv -----
// Back end: walks a job slot by slot (command, address, digits) into a
// registered output byte. Uses dssfe_pkg for the job type and segment table.
`timescale 1ns / 1ps
`default_nettype none

module dssfe_back
  import dssfe_pkg::*;
(
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire dssfe_job_t    job_i,
  input  wire dssfe_q_stat_t q_stat_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output logic [7:0]         bus_byte_o,
  output logic               opens_o,
  output logic               closes_o,
  output logic               last_o
);

  logic [SlotW-1:0]     slot_q, slot_d;
  logic                 ov_q, ov_d;
  logic [7:0]           byte_q, byte_d;
  logic                 open_q, open_d;
  logic                 close_q, close_d;
  logic                 last_q, last_d;

  logic                 load;
  logic                 emit;
  logic                 fin;
  logic [SlotW-1:0]     sel;
  logic [7:0]           digit_byte;

  assign load = !ov_q || out_ready_i;
  assign emit = load && q_stat_i.valid;

  // digit slots count down from the most significant shown digit
  assign sel        = SlotW'(job_i.n_digits) + SlotW'(1) - slot_q;
  assign digit_byte = seg7(job_i.digits[sel[DigitIdxW-1:0]]);

  always_comb begin
    byte_d  = byte_q;
    open_d  = open_q;
    close_d = close_q;
    last_d  = last_q;
    fin     = 1'b0;
    case (slot_q)
      SlotCommand: begin
        byte_d  = DataCommand;
        open_d  = 1'b1;
        close_d = 1'b1;
        fin     = 1'b0;
      end
      SlotAddress: begin
        byte_d  = job_i.start_position + AddrBase - 8'd1;
        open_d  = 1'b1;
        fin     = (job_i.n_digits == '0);
        close_d = fin;
      end
      default: begin
        fin     = (slot_q == SlotW'(job_i.n_digits) + SlotW'(1));
        byte_d  = (fin && job_i.point_on) ? (digit_byte | PointBit) : digit_byte;
        open_d  = 1'b0;
        close_d = fin;
      end
    endcase
    last_d = fin;

    ov_d   = load ? q_stat_i.valid : ov_q;
    slot_d = emit ? (fin ? SlotCommand : slot_q + SlotW'(1)) : slot_q;
    pop_o  = emit && fin;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q   <= 1'b0;
      slot_q <= SlotCommand;
    end else begin
      ov_q   <= ov_d;
      slot_q <= slot_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      byte_q  <= byte_d;
      open_q  <= open_d;
      close_q <= close_d;
      last_q  <= last_d;
    end
  end

  assign out_valid_o = ov_q;
  assign bus_byte_o  = byte_q;
  assign opens_o     = open_q;
  assign closes_o    = close_q;
  assign last_o      = last_q;

endmodule

`default_nettype wire

// ----- rtl/decimal_seven_segment_frame_encoder_unit.sv -----
// Top level of the decimal seven-segment frame encoder.
// Depends on dssfe_pkg, dssfe_if, dssfe_front, dssfe_queue and dssfe_back.
//
//   port     dir  modport  payload
//   req_i    in   sink     start_position, count_of_digits, value_to_show, point_on
//   frame_o  out  source   bus_byte, opens_transfer, closes_transfer, last_of_run
//
// Each request yields 2 + n bytes (n = digit count saturated to 8), one per cycle
// while the output does not stall. Per request the front end runs 8 digit steps of
// the divide-by-ten multiplier, then a push, and accepts the next request meanwhile.
// Reset clears control state only; no clearing pass. While the output stalls, up to
// two converted jobs wait in the queue, one converted job waits in the front end
// for a free slot and one request waits in the input hold.
`timescale 1ns / 1ps
`default_nettype none

module decimal_seven_segment_frame_encoder_unit
  import dssfe_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  dssfe_req_if.sink    req_i,
  dssfe_byte_if.source frame_o
);

  dssfe_req_t    req;
  dssfe_job_t    push_job;
  dssfe_job_t    head_job;
  dssfe_q_stat_t q_stat;
  logic          push;
  logic          pop;

  assign req.start_position  = req_i.start_position;
  assign req.count_of_digits = req_i.count_of_digits;
  assign req.value_to_show   = req_i.value_to_show;
  assign req.point_on        = req_i.point_on;

  dssfe_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (req_i.ready),
    .req_i      (req),
    .q_stat_i   (q_stat),
    .push_o     (push),
    .job_o      (push_job)
  );

  dssfe_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .job_i  (push_job),
    .pop_i  (pop),
    .job_o  (head_job),
    .stat_o (q_stat)
  );

  dssfe_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (head_job),
    .q_stat_i    (q_stat),
    .pop_o       (pop),
    .out_valid_o (frame_o.valid),
    .out_ready_i (frame_o.ready),
    .bus_byte_o  (frame_o.bus_byte),
    .opens_o     (frame_o.opens_transfer),
    .closes_o    (frame_o.closes_transfer),
    .last_o      (frame_o.last_of_run)
  );

endmodule

`default_nettype wire

// ----- rtl/dssfe_checker.sv -----
// Port-level checks for the frame encoder, bound to the top level.
// Depends on dssfe_pkg for the frame constants.
`timescale 1ns / 1ps
`default_nettype none

module dssfe_checker
  import dssfe_pkg::*;
(
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       out_valid_i,
  input wire logic       out_ready_i,
  input wire logic [7:0] bus_byte_i,
  input wire logic       opens_i,
  input wire logic       closes_i,
  input wire logic       last_i
);

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(bus_byte_i))
    else $error("output byte changed under stall");

  a_last_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && last_i |-> closes_i)
    else $error("final byte of a run does not close its transfer");

  a_command_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && opens_i && closes_i && !last_i |-> bus_byte_i == DataCommand)
    else $error("standalone transfer is not the data command");

  a_reset_idle: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid_i)
    else $error("output valid right after reset");

endmodule

bind decimal_seven_segment_frame_encoder_unit dssfe_checker u_dssfe_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (frame_o.valid),
  .out_ready_i (frame_o.ready),
  .bus_byte_i  (frame_o.bus_byte),
  .opens_i     (frame_o.opens_transfer),
  .closes_i    (frame_o.closes_transfer),
  .last_i      (frame_o.last_of_run)
);

`default_nettype wire
